/* rtl/mrm_pkg.sv */
// Shared types, constants and the CRC step for the Modbus RTU master engine.
package mrm_pkg;

  localparam int RX_BYTES = 64;
  localparam int RX_AW = $clog2(RX_BYTES);
  localparam int RX_CW = RX_AW + 1;
  localparam int MAX_WORDS = 31;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_BYTE  = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_WORD = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic       CFG_TIMEOUT = 1'b0;
  localparam logic       CFG_RETRY   = 1'b1;

  localparam logic [15:0] CRC_INIT = 16'hffff;
  localparam logic [15:0] CRC_POLY = 16'ha001;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        is_req;
    logic [7:0]  slave_id;
    logic [7:0]  function_code;
    logic [15:0] start_addr;
    logic [15:0] reg_value;
    logic [7:0]  rx_byte;
    logic        rx_end;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] data_word;
    logic [4:0]  word_count;
    logic        success;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [7:0]  retry_limit;
  } cfg_t;

  // One byte of CRC-16/Modbus, bit by bit over the reflected polynomial.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage

/* rtl/mrm_front.sv */
// Input queue that accepts and classifies items ahead of the engine.
module mrm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [1:0]          in_opcode,
  input  logic [7:0]          in_slave_id,
  input  logic [7:0]          in_function_code,
  input  logic [15:0]         in_start_addr,
  input  logic [15:0]         in_reg_value,
  input  logic [7:0]          in_rx_byte,
  input  logic                in_rx_end,
  output logic                item_valid,
  output mrm_pkg::item_t      item,
  input  logic                item_pop
);

  mrm_pkg::item_t q_r [mrm_pkg::QDEPTH];
  logic [mrm_pkg::QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [mrm_pkg::QAW:0]   cnt_r, cnt_nxt;
  logic do_push, do_pop;
  mrm_pkg::item_t new_item;

  assign in_full    = (cnt_r == (mrm_pkg::QAW+1)'(mrm_pkg::QDEPTH));
  assign item_valid = (cnt_r != '0);
  assign item       = q_r[rp_r];
  assign do_push    = in_push && !in_full;
  assign do_pop     = item_pop && item_valid;

  // Classify the item as a request or a receive-side event.
  always_comb begin
    new_item.opcode        = in_opcode;
    new_item.is_req        = (in_opcode == mrm_pkg::OP_READ) ||
                             (in_opcode == mrm_pkg::OP_WRITE);
    new_item.slave_id      = in_slave_id;
    new_item.function_code = in_function_code;
    new_item.start_addr    = in_start_addr;
    new_item.reg_value     = in_reg_value;
    new_item.rx_byte       = in_rx_byte;
    new_item.rx_end        = in_rx_end;
  end

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (mrm_pkg::QAW+1)'(do_push) - (mrm_pkg::QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= new_item;
  end

endmodule

/* rtl/mrm_resq.sv */
// Result queue that parts the engine from the result consumer.
module mrm_resq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_push,
  input  mrm_pkg::res_t  res,
  output logic           res_room,
  output logic           out_empty,
  input  logic           out_pop,
  output mrm_pkg::res_t  head
);

  mrm_pkg::res_t q_r [mrm_pkg::QDEPTH];
  logic [mrm_pkg::QAW-1:0] wp_r, rp_r;
  logic [mrm_pkg::QAW:0]   cnt_r;
  logic do_push, do_pop;

  assign res_room  = (cnt_r != (mrm_pkg::QAW+1)'(mrm_pkg::QDEPTH));
  assign out_empty = (cnt_r == '0);
  assign head      = q_r[rp_r];
  assign do_push   = res_push && res_room;
  assign do_pop    = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (mrm_pkg::QAW+1)'(do_push) - (mrm_pkg::QAW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= res;
  end

endmodule

/* rtl/mrm_engine.sv */
// Transaction sequencer: frame transmit, response capture, check and word readout.
module mrm_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  mrm_pkg::cfg_t   cfg,
  input  logic            item_valid,
  input  mrm_pkg::item_t  item,
  output logic            item_pop,
  output logic            res_push,
  output mrm_pkg::res_t   res,
  input  logic            res_room
);

  localparam logic [2:0] B_FETCH = 3'd0;
  localparam logic [2:0] B_START = 3'd1;
  localparam logic [2:0] B_TX    = 3'd2;
  localparam logic [2:0] B_CHK   = 3'd3;
  localparam logic [2:0] B_WADDR = 3'd4;
  localparam logic [2:0] B_WEMIT = 3'd5;
  localparam logic [2:0] B_DONE  = 3'd6;

  logic [2:0]  st_r, st_nxt;
  logic        phase_r, phase_nxt;
  logic        is_read_r, is_read_nxt;
  logic [47:0] req_r, req_nxt;
  logic [7:0]  att_r, att_nxt;
  logic [15:0] wt_r, wt_nxt;
  logic [mrm_pkg::RX_CW-1:0] cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] txcrc_r, txcrc_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        id_ok_r, id_ok_nxt, fc_ok_r, fc_ok_nxt;
  logic [7:0]  bc_r, bc_nxt;
  logic [4:0]  wi_r, wi_nxt;
  logic [mrm_pkg::RX_AW-1:0] ahi_r, ahi_nxt, alo_r, alo_nxt;
  logic        mem_we;
  logic [7:0]  mem [mrm_pkg::RX_BYTES];
  logic [7:0]  rd_hi_r, rd_lo_r;
  logic [7:0]  tx_b;
  logic [15:0] wt_inc;
  logic        frame_ok;
  logic [4:0]  words;

  assign words  = bc_r[5:1];
  assign wt_inc = wt_r + 16'd1;

  // Frame byte selected by the transmit index.
  always_comb begin
    case (idx_r)
      3'd0:    tx_b = req_r[47:40];
      3'd1:    tx_b = req_r[39:32];
      3'd2:    tx_b = req_r[31:24];
      3'd3:    tx_b = req_r[23:16];
      3'd4:    tx_b = req_r[15:8];
      3'd5:    tx_b = req_r[7:0];
      3'd6:    tx_b = txcrc_r[7:0];
      default: tx_b = txcrc_r[15:8];
    endcase
  end

  // Response check: header, CRC residue, length and word count.
  always_comb begin
    frame_ok = !ovf_r && (cnt_r >= mrm_pkg::RX_CW'(4)) && id_ok_r && fc_ok_r &&
               (crc_r == 16'h0000);
    if (is_read_r && (({2'b00, cnt_r} < 9'd5 + {1'b0, bc_r}) ||
                      ({1'b0, bc_r[7:1]} > 8'(mrm_pkg::MAX_WORDS))))
      frame_ok = 1'b0;
  end

  // Sequencer.
  always_comb begin
    st_nxt = st_r; phase_nxt = phase_r; is_read_nxt = is_read_r; req_nxt = req_r;
    att_nxt = att_r; wt_nxt = wt_r; cnt_nxt = cnt_r; ovf_nxt = ovf_r; crc_nxt = crc_r;
    txcrc_nxt = txcrc_r; idx_nxt = idx_r; id_ok_nxt = id_ok_r; fc_ok_nxt = fc_ok_r;
    bc_nxt = bc_r; wi_nxt = wi_r; ahi_nxt = ahi_r; alo_nxt = alo_r;
    item_pop = 1'b0; mem_we = 1'b0; res_push = 1'b0; res = '0;
    unique case (st_r)
      B_FETCH: begin
        if (item_valid) begin
          item_pop = 1'b1;
          if (item.is_req) begin
            if (!phase_r) begin
              req_nxt = {item.slave_id, item.function_code, item.start_addr, item.reg_value};
              is_read_nxt = (item.opcode == mrm_pkg::OP_READ);
              att_nxt = cfg.retry_limit;
              st_nxt = B_START;
            end
          end else if (phase_r) begin
            if (item.opcode == mrm_pkg::OP_BYTE) begin
              wt_nxt = '0;
              if (cnt_r < mrm_pkg::RX_CW'(mrm_pkg::RX_BYTES)) begin
                mem_we = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
                if (cnt_r == mrm_pkg::RX_CW'(0)) id_ok_nxt = (item.rx_byte == req_r[47:40]);
                if (cnt_r == mrm_pkg::RX_CW'(1)) fc_ok_nxt = (item.rx_byte == req_r[39:32]);
                if (cnt_r == mrm_pkg::RX_CW'(2)) bc_nxt = item.rx_byte;
              end else begin
                ovf_nxt = 1'b1;
              end
              crc_nxt = mrm_pkg::crc_byte(crc_r, item.rx_byte);
              if (item.rx_end) st_nxt = B_CHK;
            end else begin
              wt_nxt = wt_inc;
              if (wt_inc >= cfg.timeout_ms) st_nxt = B_START;
            end
          end
        end
      end
      B_START: begin
        // Either give up or begin another attempt; receive state starts clean.
        if (att_r == 8'd0) begin
          if (res_room) begin
            res_push = 1'b1;
            res.kind = mrm_pkg::KIND_DONE;
            res.last = 1'b1;
            phase_nxt = 1'b0;
            cnt_nxt = '0; ovf_nxt = 1'b0; crc_nxt = mrm_pkg::CRC_INIT; wt_nxt = '0;
            st_nxt = B_FETCH;
          end
        end else begin
          att_nxt = att_r - 8'd1;
          cnt_nxt = '0; ovf_nxt = 1'b0; crc_nxt = mrm_pkg::CRC_INIT; wt_nxt = '0;
          txcrc_nxt = mrm_pkg::CRC_INIT;
          idx_nxt = '0;
          phase_nxt = 1'b1;
          st_nxt = B_TX;
        end
      end
      B_TX: begin
        if (res_room) begin
          res_push = 1'b1;
          res.kind = mrm_pkg::KIND_TX;
          res.tx_byte = tx_b;
          res.last = (idx_r == 3'd7);
          if (idx_r < 3'd6) txcrc_nxt = mrm_pkg::crc_byte(txcrc_r, tx_b);
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) st_nxt = B_FETCH;
        end
      end
      B_CHK: begin
        wi_nxt = '0;
        if (!frame_ok) st_nxt = B_START;
        else if (is_read_r && (words != 5'd0)) st_nxt = B_WADDR;
        else st_nxt = B_DONE;
      end
      B_WADDR: begin
        ahi_nxt = mrm_pkg::RX_AW'(7'd3 + {1'b0, wi_r, 1'b0});
        alo_nxt = mrm_pkg::RX_AW'(7'd4 + {1'b0, wi_r, 1'b0});
        st_nxt = B_WEMIT;
      end
      B_WEMIT: begin
        if (res_room) begin
          res_push = 1'b1;
          res.kind = mrm_pkg::KIND_WORD;
          res.data_word = {rd_hi_r, rd_lo_r};
          wi_nxt = wi_r + 5'd1;
          st_nxt = (wi_r + 5'd1 == words) ? B_DONE : B_WADDR;
        end
      end
      B_DONE: begin
        if (res_room) begin
          res_push = 1'b1;
          res.kind = mrm_pkg::KIND_DONE;
          res.word_count = is_read_r ? words : 5'd0;
          res.success = 1'b1;
          res.last = 1'b1;
          phase_nxt = 1'b0;
          cnt_nxt = '0; ovf_nxt = 1'b0; crc_nxt = mrm_pkg::CRC_INIT; wt_nxt = '0;
          st_nxt = B_FETCH;
        end
      end
      default: st_nxt = B_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_FETCH; phase_r <= 1'b0; is_read_r <= 1'b0; req_r <= '0;
      att_r <= '0; wt_r <= '0; cnt_r <= '0; ovf_r <= 1'b0; crc_r <= mrm_pkg::CRC_INIT;
    end else begin
      st_r <= st_nxt; phase_r <= phase_nxt; is_read_r <= is_read_nxt; req_r <= req_nxt;
      att_r <= att_nxt; wt_r <= wt_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt;
      crc_r <= crc_nxt;
    end
  end

  // Working registers that need no reset.
  always_ff @(posedge clk) begin
    txcrc_r <= txcrc_nxt; idx_r <= idx_nxt; id_ok_r <= id_ok_nxt; fc_ok_r <= fc_ok_nxt;
    bc_r <= bc_nxt; wi_r <= wi_nxt; ahi_r <= ahi_nxt; alo_r <= alo_nxt;
  end

  // Response byte store: one write port, two registered read ports. The read
  // address is taken from the next-address value so the word pair is ready in
  // the cycle right after the address step.
  always_ff @(posedge clk) begin
    if (mem_we) mem[cnt_r[mrm_pkg::RX_AW-1:0]] <= item.rx_byte;
    rd_hi_r <= mem[ahi_nxt];
    rd_lo_r <= mem[alo_nxt];
  end

  a_tx_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_TX |-> phase_r) else $error("transmit while not waiting");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mrm_pkg::RX_CW'(mrm_pkg::RX_BYTES)) else $error("receive count overrun");
  a_word_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res.kind == mrm_pkg::KIND_WORD |-> !res.last)
    else $error("data word marked last");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res_room && res.kind == mrm_pkg::KIND_DONE |=> !phase_r)
    else $error("still waiting after completion");

endmodule

/* rtl/modbus_rtu_master_transaction.sv */
// Top level of the Modbus RTU master transaction engine.
// Each input item is queued and then handled by one sequencer, one at a time. A received
// byte or a tick is taken in the fetch state; a request or a retry emits its 8 frame bytes
// at one per cycle while the result queue has room, after a start step; a good read response
// passes a check step, then an address step and an emit step per data word (the response
// store's registered read) and then the completion, for up to 29 words. The result queue
// holds four results; when it is full the sequencer waits. Configuration is always ready:
// index 0 timeout_ms, index 1 retry_limit (low 8 bits of the data).
module modbus_rtu_master_transaction (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_slave_id,
  input  logic [7:0]  in_function_code,
  input  logic [15:0] in_start_addr,
  input  logic [15:0] in_reg_value,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_rx_end,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic [15:0] out_data_word,
  output logic [4:0]  out_word_count,
  output logic        out_success,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  mrm_pkg::cfg_t  cfg_r;
  mrm_pkg::item_t item;
  mrm_pkg::res_t  res, head;
  logic item_valid, item_pop, res_push, res_room;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ms  <= 16'd100;
      cfg_r.retry_limit <= 8'd3;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == mrm_pkg::CFG_TIMEOUT) cfg_r.timeout_ms <= cfg_data;
      if (cfg_index == mrm_pkg::CFG_RETRY) cfg_r.retry_limit <= cfg_data[7:0];
    end
  end

  mrm_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_opcode, .in_slave_id, .in_function_code,
    .in_start_addr, .in_reg_value, .in_rx_byte, .in_rx_end,
    .item_valid, .item, .item_pop
  );

  mrm_engine u_engine (
    .clk, .rst_n, .cfg(cfg_r), .item_valid, .item, .item_pop, .res_push, .res, .res_room
  );

  mrm_resq u_resq (
    .clk, .rst_n, .res_push, .res, .res_room, .out_empty, .out_pop, .head
  );

  assign out_kind       = head.kind;
  assign out_tx_byte    = head.tx_byte;
  assign out_data_word  = head.data_word;
  assign out_word_count = head.word_count;
  assign out_success    = head.success;
  assign out_last       = head.last;

endmodule
